// ----- rtl/core/mwdiv_pkg.sv -----
// Package: widths, item types and controller state for the multiword divider.
package mwdiv_pkg;
  localparam int unsigned Words = 4;
  localparam int unsigned WordW = 32;
  localparam int unsigned WideW = Words * WordW;
  localparam int unsigned IdxW = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned BitW = $clog2(WideW);

  typedef struct packed {
    logic [WordW-1:0] dividend_word;
    logic [WordW-1:0] divisor_word;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] quotient_word;
    logic [WordW-1:0] remainder_word;
    logic             status;
    logic             last_word;
  } out_item_t;

  typedef enum logic [3:0] {
    StLoad = 4'b0001,
    StInit = 4'b0010,
    StCalc = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  typedef struct packed {
    logic load;
    logic init;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic div_zero;
  } dp_sts_t;
endpackage

// ----- rtl/core/multiword_unsigned_divider.sv -----
// Top level: multiword unsigned divider, one bit of quotient per cycle.
// Takes Words item pairs (least significant word first), then runs a restoring
// division over the Words*32-bit operands, starting with an init step after the
// last item, one quotient bit per clock in a single shared subtractor, then
// emits Words results, one per cycle when not stalled. Input stall is high
// from the last item until the final result is taken; a zero divisor sets
// status and zeroes both result words.
module multiword_unsigned_divider import mwdiv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);
  logic            in_ready, in_fire, out_fire, out_last;
  logic [IdxW-1:0] sel;
  dp_cmd_t         cmd;
  dp_sts_t         sts;
  logic [WordW-1:0] quot, rem;

  assign in_stall_o = !in_ready;
  assign in_fire    = in_valid_i && in_ready;
  assign out_fire   = out_valid_o && !out_stall_i;

  mwdiv_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i(in_fire), .out_fire_i(out_fire), .in_ready_o(in_ready),
    .out_valid_o, .out_last_o(out_last), .sel_o(sel), .cmd_o(cmd)
  );

  mwdiv_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .in_i(in_data_i), .sel_i(sel),
    .sts_o(sts), .quot_o(quot), .rem_o(rem)
  );

  assign out_data_o.quotient_word  = quot;
  assign out_data_o.remainder_word = rem;
  assign out_data_o.status         = sts.div_zero;
  assign out_data_o.last_word      = out_last;
endmodule

// ----- rtl/core/mwdiv_datapath.sv -----
// Datapath: operand shift registers, restoring divide step, result words.
module mwdiv_datapath import mwdiv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_cmd_t          cmd_i,
  input  in_item_t         in_i,
  input  logic [IdxW-1:0]  sel_i,
  output dp_sts_t          sts_o,
  output logic [WordW-1:0] quot_o,
  output logic [WordW-1:0] rem_o
);
  logic [WideW-1:0] dvd_q, dvd_d, dvs_q, dvs_d, rem_q, rem_d;
  logic             zero_q, zero_d;
  logic [WideW:0]   shifted, diff;

  assign shifted = {rem_q, dvd_q[WideW-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    zero_d = zero_q;
    if (cmd_i.load) begin
      dvd_d = {in_i.dividend_word, dvd_q[WideW-1:WordW]};
      dvs_d = {in_i.divisor_word, dvs_q[WideW-1:WordW]};
    end else if (cmd_i.init) begin
      rem_d  = '0;
      zero_d = (dvs_q == '0);
    end else if (cmd_i.step) begin
      if (!diff[WideW]) begin
        rem_d = diff[WideW-1:0];
      end else begin
        rem_d = shifted[WideW-1:0];
      end
      dvd_d = {dvd_q[WideW-2:0], ~diff[WideW]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= 1'b0;
    end else begin
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign sts_o.div_zero = zero_q;
  assign quot_o = zero_q ? '0 : dvd_q[sel_i*WordW +: WordW];
  assign rem_o  = zero_q ? '0 : rem_q[sel_i*WordW +: WordW];
endmodule

// ----- rtl/core/mwdiv_ctrl.sv -----
// Controller: sequences load, divide and emit phases.
module mwdiv_ctrl import mwdiv_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_fire_i,
  input  logic            out_fire_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output logic            out_last_o,
  output logic [IdxW-1:0] sel_o,
  output dp_cmd_t         cmd_o
);
  state_e          state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic [BitW-1:0] bit_q, bit_d;

  assign in_ready_o  = (state_q == StLoad);
  assign out_valid_o = (state_q == StEmit);
  assign out_last_o  = (cnt_q == IdxW'(Words - 1));
  assign sel_o       = cnt_q;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    bit_d    = bit_q;
    cmd_o    = '0;
    unique case (state_q)
      StLoad: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          if (cnt_q == IdxW'(Words - 1)) begin
            cnt_d   = '0;
            state_d = StInit;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        bit_d      = '0;
        state_d    = StCalc;
      end
      StCalc: begin
        cmd_o.step = 1'b1;
        bit_d      = bit_q + 1'b1;
        if (bit_q == BitW'(WideW - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_fire_i) begin
          if (cnt_q == IdxW'(Words - 1)) begin
            cnt_d   = '0;
            state_d = StLoad;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      bit_q   <= bit_d;
    end
  end
endmodule
